// ===== rtl/rwd_pkg.sv =====
// ----------------------------------------------------------------------------
// rwd_pkg
// Shared types, constants and the microcode table for the receive-window
// duplicate filter and ack generator.
// ----------------------------------------------------------------------------
package rwd_pkg;

  localparam int unsigned WINDOW_DEPTH_DEF = 16;
  localparam int unsigned ID_W             = 16;
  localparam int unsigned ACK_SPAN         = 16;
  localparam int unsigned ACK_POS_W        = $clog2(ACK_SPAN);
  localparam int unsigned STEP_W           = 3;

  typedef logic [STEP_W-1:0] step_t;

  // Program addresses.
  localparam step_t STEP_IDLE   = 3'd0;
  localparam step_t STEP_FIND   = 3'd1;
  localparam step_t STEP_COMMIT = 3'd2;
  localparam step_t STEP_BITS   = 3'd3;
  localparam step_t STEP_EMIT   = 3'd4;
  localparam step_t STEP_RETURN = 3'd5;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_SCAN_MORE,
    COND_OUT_BUSY
  } cond_e;

  typedef struct packed {
    logic  take_in;
    logic  scan_find;
    logic  commit;
    logic  scan_bits;
    logic  emit;
    cond_e cond;
    step_t target;
  } ctrl_word_t;

  typedef struct packed {
    logic in_valid;
    logic scan_more;
    logic out_busy;
  } seq_status_t;

  // The control program. Each step either falls through to the next
  // address or jumps to its target when its condition holds.
  function automatic ctrl_word_t ucode_rom(step_t addr);
    ctrl_word_t w;
    w = '{take_in: 1'b0, scan_find: 1'b0, commit: 1'b0, scan_bits: 1'b0,
          emit: 1'b0, cond: COND_ALWAYS, target: STEP_IDLE};
    unique case (addr)
      STEP_IDLE: begin
        w.take_in = 1'b1;
        w.cond    = COND_NO_INPUT;
        w.target  = STEP_IDLE;
      end
      STEP_FIND: begin
        w.scan_find = 1'b1;
        w.cond      = COND_SCAN_MORE;
        w.target    = STEP_FIND;
      end
      STEP_COMMIT: begin
        w.commit = 1'b1;
        w.cond   = COND_NEVER;
      end
      STEP_BITS: begin
        w.scan_bits = 1'b1;
        w.cond      = COND_SCAN_MORE;
        w.target    = STEP_BITS;
      end
      STEP_EMIT: begin
        w.emit   = 1'b1;
        w.cond   = COND_OUT_BUSY;
        w.target = STEP_EMIT;
      end
      STEP_RETURN: begin
        w.cond   = COND_ALWAYS;
        w.target = STEP_IDLE;
      end
      default: begin
        w.cond   = COND_ALWAYS;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/receive_window_dedup_ack_bitfield.sv =====
// ----------------------------------------------------------------------------
// receive_window_dedup_ack_bitfield
// Receive-side duplicate filter with ack and ack bitfield generation over a
// window of the most recently recorded sequence ids.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                 Payload
//   -------   ---------  ------------------------  -------------------------
//   input     in         in_valid_i / in_stall_o   seq_id_i
//   output    out        out_valid_o / out_stall_i is_repeat_o, ack_valid_o,
//                                                  ack_id_o, ack_bits_o
//
// One transaction in gives exactly one transaction out. An item is taken
// in the idle step, then passes the find sweep, the commit step, the bits
// sweep and the emit step before the result register is loaded. The window
// has a single read port and is swept twice: once for the repeat check and
// the maxima, once for the ack bitfield. No new input transaction is taken
// until the current item has left its emit step. Reset clears the
// sequencer, the fill count, the eviction pointer, the scan index and the
// output valid; no clearing pass is needed. A result waiting on a stalled
// output does not hold up the next input transaction until its emit step is
// reached.
//
module receive_window_dedup_ack_bitfield import rwd_pkg::*; #(
  parameter int unsigned WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [ID_W-1:0] seq_id_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic            is_repeat_o,
  output logic            ack_valid_o,
  output logic [ID_W-1:0] ack_id_o,
  output logic [ID_W-1:0] ack_bits_o
);

  // Fill count and scan index must hold WINDOW_DEPTH itself; slot pointers
  // only address the entries.
  localparam int unsigned CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(WINDOW_DEPTH);
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(WINDOW_DEPTH - 1);

  ctrl_word_t  ctrl;
  seq_status_t status;

  // Window storage. Entries at and above the fill count are never read, so
  // the array needs no reset.
  logic [ID_W-1:0] window_q [WINDOW_DEPTH];

  logic [CNT_W-1:0] fill_q;
  logic [IDX_W-1:0] oldest_q;
  logic [CNT_W-1:0] idx_q;

  logic [ID_W-1:0] id_q;
  logic            hit_q;
  logic [ID_W-1:0] max_all_q;   // maximum over every held entry
  logic [ID_W-1:0] max_keep_q;  // maximum over entries that survive eviction
  logic [ID_W-1:0] ack_q;
  logic [ID_W-1:0] bits_q;
  logic            repeat_q;

  logic            out_valid_q;
  logic            is_repeat_q;
  logic            ack_valid_q;
  logic [ID_W-1:0] ack_id_q;
  logic [ID_W-1:0] ack_bits_q;

  logic             scan_more;
  logic [ID_W-1:0]  entry;
  logic             full;
  logic             evict_slot;
  logic             append;
  logic [ID_W-1:0]  ack_d;
  logic [ID_W-1:0]  id_gap;
  logic             gap_in_span;
  logic [ACK_POS_W-1:0] bit_pos;
  logic             out_busy;
  logic             in_fire;

  rwd_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  assign scan_more = (idx_q < fill_q);
  assign entry     = window_q[idx_q[IDX_W-1:0]];
  assign full      = (fill_q == FULL_CNT);
  // When full, the entry at the oldest pointer is the one a new id replaces.
  assign evict_slot = full && (idx_q == CNT_W'(oldest_q));
  assign append     = (id_q != '0) && !hit_q;
  always_comb begin
    if (append) begin
      ack_d = (id_q > max_keep_q) ? id_q : max_keep_q;
    end else begin
      ack_d = max_all_q;
    end
  end

  // ack_q is the window maximum, so the distance never underflows. A
  // distance of d marks bit d-1 of the field.
  assign id_gap      = ack_q - entry;
  assign gap_in_span = (id_gap != '0) && (id_gap <= ID_W'(ACK_SPAN));
  assign bit_pos     = ACK_POS_W'(id_gap - ID_W'(1));

  assign out_busy = out_valid_q && out_stall_i;
  assign in_fire  = ctrl.take_in && in_valid_i;

  assign status.in_valid  = in_valid_i;
  assign status.scan_more = scan_more;
  assign status.out_busy  = out_busy;

  assign in_stall_o = !ctrl.take_in;

  // Datapath driven by the control word.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      id_q       <= seq_id_i;
      hit_q      <= 1'b0;
      max_all_q  <= '0;
      max_keep_q <= '0;
    end
    if (ctrl.scan_find && scan_more) begin
      if ((entry == id_q) && (id_q != '0)) begin
        hit_q <= 1'b1;
      end
      if (entry > max_all_q) begin
        max_all_q <= entry;
      end
      if (!evict_slot && (entry > max_keep_q)) begin
        max_keep_q <= entry;
      end
    end
    if (ctrl.commit) begin
      ack_q    <= ack_d;
      bits_q   <= '0;
      repeat_q <= hit_q;
      if (append) begin
        if (full) begin
          window_q[oldest_q] <= id_q;
        end else begin
          window_q[fill_q[IDX_W-1:0]] <= id_q;
        end
      end
    end
    if (ctrl.scan_bits && scan_more && gap_in_span) begin
      bits_q[bit_pos] <= 1'b1;
    end
    if (ctrl.emit && !out_busy) begin
      is_repeat_q <= repeat_q;
      ack_valid_q <= (fill_q != '0);
      ack_id_q    <= ack_q;
      ack_bits_q  <= bits_q;
    end
  end

  // Control state: fill count, eviction pointer, scan index, output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      oldest_q    <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire || ctrl.commit) begin
        idx_q <= '0;
      end else if ((ctrl.scan_find || ctrl.scan_bits) && scan_more) begin
        idx_q <= idx_q + CNT_W'(1);
      end
      if (ctrl.commit && append) begin
        if (full) begin
          oldest_q <= (oldest_q == LAST_SLOT) ? '0 : oldest_q + IDX_W'(1);
        end else begin
          fill_q <= fill_q + CNT_W'(1);
        end
      end
      if (ctrl.emit && !out_busy) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign is_repeat_o = is_repeat_q;
  assign ack_valid_o = ack_valid_q;
  assign ack_id_o    = ack_id_q;
  assign ack_bits_o  = ack_bits_q;

  // The fill count never passes the window depth, and the eviction pointer
  // stays on a real slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q <= FULL_CNT) && (oldest_q <= LAST_SLOT))
    else $error("window fill or eviction pointer out of range");

  // The eviction pointer only moves once the window is full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (oldest_q != '0) |-> full)
    else $error("eviction pointer moved before the window filled");

  // A repeat can only be reported against a non-empty window.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_repeat_o) |-> ack_valid_o)
    else $error("repeat reported with an empty window");

  // An empty window carries no ack bits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (ack_bits_o != '0)) |-> ack_valid_o)
    else $error("ack bits set with an empty window");

  // An accepted transaction keeps the input stalled while it is processed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken again before the current item finished");

endmodule

// ===== rtl/rwd_sequencer.sv =====
// ----------------------------------------------------------------------------
// rwd_sequencer
// Step counter and microcode table lookup with conditional jumps.
// ----------------------------------------------------------------------------
module rwd_sequencer import rwd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  seq_status_t status_i,
  output ctrl_word_t  ctrl_o
);

  step_t      pc_q, pc_d;
  ctrl_word_t ctrl;
  logic       take;

  assign ctrl   = ucode_rom(pc_q);
  assign ctrl_o = ctrl;

  always_comb begin
    unique case (ctrl.cond)
      COND_NEVER:     take = 1'b0;
      COND_ALWAYS:    take = 1'b1;
      COND_NO_INPUT:  take = !status_i.in_valid;
      COND_SCAN_MORE: take = status_i.scan_more;
      COND_OUT_BUSY:  take = status_i.out_busy;
      default:        take = 1'b1;
    endcase
    pc_d = take ? ctrl.target : step_t'(pc_q + step_t'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

// ===== dv/tb_receive_window_dedup_ack_bitfield.sv =====
// ----------------------------------------------------------------------------
// tb_receive_window_dedup_ack_bitfield
// Self-checking testbench for the receive-window duplicate filter. Sequence
// ids are pushed through the input channel. A local copy of the window
// predicts the repeat flag, the ack and the ack bitfield for every accepted
// transaction. Results are compared field by field, in order, as they leave
// the output channel. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_receive_window_dedup_ack_bitfield;
  timeunit 1ns;
  timeprecision 1ps;

  import rwd_pkg::*;

  localparam int unsigned DEPTH        = WINDOW_DEPTH_DEF;
  // The block sweeps the window twice per item; this margin covers any result
  // still in flight once the queue has drained.
  localparam int unsigned DRAIN_CYCLES = 2 * DEPTH + 16;
  localparam int unsigned HISTORY_LEN  = 24;
  localparam int unsigned MAX_REPORTS  = 40;

  typedef struct {
    logic            is_repeat;
    logic            ack_valid;
    logic [ID_W-1:0] ack_id;
    logic [ID_W-1:0] ack_bits;
  } ack_result_t;

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            in_valid_i  = 1'b0;
  logic            in_stall_o;
  logic [ID_W-1:0] seq_id_i    = '0;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  logic            is_repeat_o;
  logic            ack_valid_o;
  logic [ID_W-1:0] ack_id_o;
  logic [ID_W-1:0] ack_bits_o;

  // Local copy of the receive window, kept in step with accepted transactions.
  logic [ID_W-1:0] window_ids [DEPTH];
  int unsigned     window_fill;
  int unsigned     evict_slot;

  ack_result_t     expected_acks [$];
  logic [ID_W-1:0] sent_history [$];
  logic [ID_W-1:0] stream_base;

  // Percentage of transactions followed by a gap on the input side, and the
  // percentage of cycles on which the output side starts a stall.
  int unsigned     in_gap_pct;
  int unsigned     out_stall_pct;
  int unsigned     stall_left;
  int unsigned     error_count;
  int unsigned     acks_checked;

  receive_window_dedup_ack_bitfield #(
    .WINDOW_DEPTH(DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .seq_id_i   (seq_id_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .is_repeat_o(is_repeat_o),
    .ack_valid_o(ack_valid_o),
    .ack_id_o   (ack_id_o),
    .ack_bits_o (ack_bits_o)
  );

  // 8 ns clock period.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Window predictor
  // --------------------------------------------------------------------------

  // Id zero is never held, so looking it up always misses.
  function automatic bit window_holds(input int unsigned id);
    if (id == 0) return 1'b0;
    for (int unsigned k = 0; k < window_fill; k++) begin
      if (window_ids[k] == id) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Updates the local window with one received id and returns the result
  // that the block must give for it.
  function automatic ack_result_t predict_ack(input logic [ID_W-1:0] id);
    ack_result_t res;
    int unsigned top;
    res = '{is_repeat: 1'b0, ack_valid: 1'b0, ack_id: '0, ack_bits: '0};
    if (id != 0) begin
      if (window_holds(id)) begin
        res.is_repeat = 1'b1;
      end else if (window_fill < DEPTH) begin
        window_ids[window_fill] = id;
        window_fill++;
      end else begin
        // A full window overwrites its oldest entry.
        window_ids[evict_slot] = id;
        evict_slot = (evict_slot + 1) % DEPTH;
      end
    end
    if (window_fill != 0) begin
      top = 0;
      for (int unsigned k = 0; k < window_fill; k++) begin
        if (window_ids[k] > top) top = window_ids[k];
      end
      res.ack_valid = 1'b1;
      res.ack_id    = top[ID_W-1:0];
      // Ids below the ack never wrap past zero; those bits stay clear.
      for (int unsigned k = 0; k < ACK_SPAN; k++) begin
        if (top >= k + 1 && window_holds(top - k - 1)) res.ack_bits[k] = 1'b1;
      end
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Most gaps are short; about one in ten is long.
  function automatic int unsigned pick_gap(input int unsigned pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(60, 12);
    return $urandom_range(3, 1);
  endfunction

  // Mostly a packet stream that creeps forward with some reordering, laced
  // with replays of recent ids, zero ids and completely random ids.
  function automatic logic [ID_W-1:0] pick_stream_id();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 8) return '0;
    if (roll < 18) return ID_W'($urandom);
    if (roll < 40 && sent_history.size() != 0) begin
      return sent_history[$urandom_range(sent_history.size() - 1)];
    end
    if ($urandom_range(39) == 0) begin
      // Move the stream, sometimes close to either end of the id range.
      case ($urandom_range(2))
        0: begin
          stream_base = ID_W'($urandom_range(20, 1));
        end
        1: begin
          stream_base = ID_W'(65535 - $urandom_range(20));
        end
        default: begin
          stream_base = ID_W'($urandom);
        end
      endcase
    end
    stream_base = ID_W'(stream_base + $urandom_range(6) - 2);
    return stream_base;
  endfunction

  // Sends one transaction, records its expected result once it has been
  // accepted, and may then leave the input idle for a while.
  task automatic send_seq_id(input logic [ID_W-1:0] id);
    int unsigned gap;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    seq_id_i   <= id;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_acks = {expected_acks, predict_ack(id)};
    if (id != 0) begin
      sent_history = {sent_history, id};
      if (sent_history.size() > HISTORY_LEN) void'(sent_history.pop_front());
    end
    gap = pick_gap(in_gap_pct);
    if (gap != 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      seq_id_i   <= ID_W'($urandom);
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // Holds the input idle until every outstanding result has been checked.
  task automatic wait_all_acked();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_acks.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_stream(input int unsigned count);
    repeat (count) send_seq_id(pick_stream_id());
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("%0t ns: result %0d, %s: got 0x%0h, expected 0x%0h",
               $time, acks_checked, what, got, want);
    end
  endtask

  // --------------------------------------------------------------------------
  // Output side: random stall and result checking
  // --------------------------------------------------------------------------

  always @(negedge clk_i) begin : drive_out_stall
    int unsigned len;
    if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left  = stall_left - 1;
    end else begin
      len = pick_gap(out_stall_pct);
      out_stall_i <= (len != 0);
      stall_left  = (len != 0) ? len - 1 : 0;
    end
  end

  // Each transaction leaving the block is matched against the oldest
  // expected result.
  always @(posedge clk_i) begin : check_acks
    ack_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_acks.size() == 0) begin
        report_mismatch("result with none expected", 32'(ack_id_o), '0);
      end else begin
        want = expected_acks.pop_front();
        if (is_repeat_o !== want.is_repeat) begin
          report_mismatch("is_repeat", 32'(is_repeat_o), 32'(want.is_repeat));
        end
        if (ack_valid_o !== want.ack_valid) begin
          report_mismatch("ack_valid", 32'(ack_valid_o), 32'(want.ack_valid));
        end
        if (ack_id_o !== want.ack_id) begin
          report_mismatch("ack_id", 32'(ack_id_o), 32'(want.ack_id));
        end
        if (ack_bits_o !== want.ack_bits) begin
          report_mismatch("ack_bits", 32'(ack_bits_o), 32'(want.ack_bits));
        end
      end
      acks_checked++;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // With nothing recorded the ack is invalid and zero, and id zero changes
  // nothing.
  task automatic test_empty_window();
    send_seq_id(16'd0);
    send_seq_id(16'd0);
  endtask

  // Smallest ids: a repeat, a zero id on a non-empty window, and a bitfield
  // whose lower candidates would fall to zero or below.
  task automatic test_low_ids();
    send_seq_id(16'd1);
    send_seq_id(16'd1);
    send_seq_id(16'd0);
    send_seq_id(16'd2);
    send_seq_id(16'd3);
    send_seq_id(16'd1);
  endtask

  // Top of the id range: the ack does not wrap, ack minus sixteen lands on
  // the top bit of the bitfield and ack minus seventeen falls outside it.
  task automatic test_top_of_range();
    send_seq_id(16'hFFFF);
    send_seq_id(16'hFFFE);
    send_seq_id(16'hFFFF);
    send_seq_id(16'hFFEF);
    send_seq_id(16'hFFEE);
    send_seq_id(16'h8000);
  endtask

  // Overfilling the window evicts the oldest ids, which then count as fresh.
  task automatic test_eviction();
    for (int unsigned k = 0; k < 10; k++) send_seq_id(ID_W'(200 + k));
    send_seq_id(16'hFFFE);
    send_seq_id(16'd2);
  endtask

  task automatic test_back_to_back();
    in_gap_pct    = 0;
    out_stall_pct = 0;
    send_stream(100);
  endtask

  task automatic test_random_idling();
    in_gap_pct    = 30;
    out_stall_pct = 30;
    send_stream(150);
  endtask

  // Short bursts, each followed by a full drain of the block.
  task automatic test_drain_pause();
    in_gap_pct    = 15;
    out_stall_pct = 25;
    repeat (5) begin
      send_stream(10);
      wait_all_acked();
    end
  endtask

  task automatic test_heavy_backpressure();
    in_gap_pct    = 10;
    out_stall_pct = 70;
    send_stream(80);
  endtask

  task automatic test_mixed_idling();
    in_gap_pct    = 50;
    out_stall_pct = 40;
    send_stream(45);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------

  initial begin
    window_fill   = 0;
    evict_slot    = 0;
    stream_base   = ID_W'($urandom_range(40, 1));
    in_gap_pct    = 20;
    out_stall_pct = 20;
    stall_left    = 0;
    error_count   = 0;
    acks_checked  = 0;
    for (int unsigned k = 0; k < DEPTH; k++) window_ids[k] = '0;

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_window();
    test_low_ids();
    test_top_of_range();
    test_eviction();
    test_back_to_back();
    test_random_idling();
    test_drain_pause();
    test_heavy_backpressure();
    test_mixed_idling();

    wait_all_acked();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: well beyond the slowest legal run, with every item meeting the
  // longest input gap, the longest output stall and the full scan time.
  initial begin
    #5_000_000;
    $display("Timeout with %0d results outstanding", expected_acks.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
